// ----- sv/bpp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_pkg: shared types and constants of the broadcast packet parser
// Packet type codes, parse phases, result item layout and queue sizing.
// ----------------------------------------------------------------------------
package bpp_pkg;

  // Type byte codes as they appear on the wire
  localparam logic [7:0] KData      = 8'd1;
  localparam logic [7:0] KGossip    = 8'd2;
  localparam logic [7:0] KRequest   = 8'd3;
  localparam logic [7:0] KHeartbeat = 8'd4;

  // Packet type as reported on results (type byte minus one)
  localparam logic [1:0] PtData      = 2'd0;
  localparam logic [1:0] PtGossip    = 2'd1;
  localparam logic [1:0] PtRequest   = 2'd2;
  localparam logic [1:0] PtHeartbeat = 2'd3;

  // Result queue depth (at least two)
  localparam int unsigned FifoDepth = 4;

  typedef enum logic [3:0] {
    PH_TYPE    = 4'd0,
    PH_ORIGIN  = 4'd1,
    PH_SEQ     = 4'd2,
    PH_LEN     = 4'd3,
    PH_PAYLOAD = 4'd4,
    PH_COUNT   = 4'd5,
    PH_NODE    = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERR     = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ID      = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_NODE    = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_TRUNC    = 2'd2,
    ERR_TRAILING = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  ptype;
    logic [63:0] origin;
    logic [63:0] sequence_res;
    logic [63:0] node_ident;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        accepted;
    err_e        error_code;
    logic        last_item;
  } item_t;

  // Up to two results per input beat, in order
  typedef struct packed {
    logic  v0;
    logic  v1;
    item_t item0;
    item_t item1;
  } parse_out_t;

endpackage

// ----- sv/bpp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_parser: per-byte packet parse
// Holds the parse state and turns each accepted byte into up to two results.
// ----------------------------------------------------------------------------
module bpp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output bpp_pkg::parse_out_t res_o
);
  import bpp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [1:0]  kind_q, kind_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] org_q, org_d;
  logic [63:0] seq_q, seq_d;
  logic [31:0] pl_q, pl_d;
  logic [15:0] hdr_q, hdr_d;
  err_e        err_q, err_d;

  logic [63:0] full;
  logic [15:0] hdr_dec;
  logic        has_item;
  item_t       itm, vrd;
  err_e        verdict;

  // Byte merged into the field being assembled, little-endian
  assign full    = acc_q | ({56'd0, byte_i} << {cnt_q, 3'b000});
  assign hdr_dec = hdr_q - 16'd1;

  // Next state and emitted results
  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    org_d    = org_q;
    seq_d    = seq_q;
    pl_d     = pl_q;
    hdr_d    = hdr_q;
    err_d    = err_q;
    has_item = 1'b0;
    itm      = '0;

    unique case (phase_q)
      PH_TYPE: begin
        if (byte_i >= KData && byte_i <= KHeartbeat) begin
          kind_d = 2'(byte_i - KData);
          if (byte_i == KGossip)         phase_d = PH_COUNT;
          else if (byte_i == KHeartbeat) phase_d = PH_NODE;
          else                           phase_d = PH_ORIGIN;
        end else begin
          kind_d  = PtData;
          err_d   = ERR_UNKNOWN;
          phase_d = PH_ERR;
        end
      end
      PH_ORIGIN: begin
        if (cnt_q == 3'd7) begin
          org_d   = full;
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PH_SEQ;
        end else begin
          acc_d = full;
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_SEQ: begin
        if (cnt_q == 3'd7) begin
          seq_d = full;
          acc_d = '0;
          cnt_d = '0;
          if (kind_q == PtData) begin
            phase_d = PH_LEN;
          end else begin
            has_item         = 1'b1;
            itm.kind         = KIND_ID;
            itm.origin       = org_q;
            itm.sequence_res = full;
            if (kind_q == PtGossip) begin
              hdr_d   = hdr_dec;
              phase_d = (hdr_dec != 16'd0) ? PH_ORIGIN : PH_DONE;
            end else begin
              phase_d = PH_DONE;
            end
          end
        end else begin
          acc_d = full;
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_LEN: begin
        if (cnt_q == 3'd3) begin
          pl_d               = full[31:0];
          acc_d              = '0;
          cnt_d              = '0;
          has_item           = 1'b1;
          itm.kind           = KIND_ID;
          itm.origin         = org_q;
          itm.sequence_res   = seq_q;
          itm.payload_length = full[31:0];
          phase_d            = (full[31:0] != 32'd0) ? PH_PAYLOAD : PH_DONE;
        end else begin
          acc_d = full;
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_PAYLOAD: begin
        has_item         = 1'b1;
        itm.kind         = KIND_PAYLOAD;
        itm.payload_byte = byte_i;
        pl_d             = pl_q - 32'd1;
        if (pl_q == 32'd1) phase_d = PH_DONE;
      end
      PH_COUNT: begin
        if (cnt_q == 3'd1) begin
          hdr_d   = full[15:0];
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = (full[15:0] != 16'd0) ? PH_ORIGIN : PH_DONE;
        end else begin
          acc_d = full;
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_NODE: begin
        if (cnt_q == 3'd7) begin
          acc_d          = '0;
          cnt_d          = '0;
          has_item       = 1'b1;
          itm.kind       = KIND_NODE;
          itm.node_ident = full;
          phase_d        = PH_DONE;
        end else begin
          acc_d = full;
          cnt_d = cnt_q + 3'd1;
        end
      end
      PH_DONE: begin
        err_d   = ERR_TRAILING;
        phase_d = PH_ERR;
      end
      default: ;
    endcase

    itm.ptype = kind_d;

    // End verdict, judged on the state after this byte
    if (phase_d == PH_DONE)                             verdict = ERR_NONE;
    else if (phase_d >= PH_ERR && err_d != ERR_NONE)    verdict = err_d;
    else                                                verdict = ERR_TRUNC;

    vrd            = '0;
    vrd.kind       = KIND_VERDICT;
    vrd.ptype      = kind_d;
    vrd.accepted   = (verdict == ERR_NONE);
    vrd.error_code = verdict;
    vrd.last_item  = 1'b1;

    itm.last_item = !last_i;

    res_o.v0    = has_item | last_i;
    res_o.v1    = has_item & last_i;
    res_o.item0 = has_item ? itm : vrd;
    res_o.item1 = vrd;

    // Every verdict returns the parser to its reset state
    if (last_i) begin
      phase_d = PH_TYPE;
      kind_d  = '0;
      cnt_d   = '0;
      acc_d   = '0;
      org_d   = '0;
      seq_d   = '0;
      pl_d    = '0;
      hdr_d   = '0;
      err_d   = ERR_NONE;
    end
  end

  // Parse state, advanced once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      kind_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      org_q   <= '0;
      seq_q   <= '0;
      pl_q    <= '0;
      hdr_q   <= '0;
      err_q   <= ERR_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      org_q   <= org_d;
      seq_q   <= seq_d;
      pl_q    <= pl_d;
      hdr_q   <= hdr_d;
      err_q   <= err_d;
    end
  end

endmodule

// ----- sv/bpp_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpp_out_fifo: result queue
// Takes up to two results a cycle, hands out one a cycle while pop_i is high.
// ----------------------------------------------------------------------------
module bpp_out_fifo #(
  parameter int unsigned DEPTH = bpp_pkg::FifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bpp_pkg::parse_out_t res_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                pop_i,
  output bpp_pkg::item_t      item_o
);
  import bpp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(DEPTH - 2);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;
  logic [1:0]      n_push;

  assign wr_nx   = ptr_inc(wr_q);
  assign do_pop  = pop_i && (cnt_q != '0);
  assign n_push  = push_i ? ({1'b0, res_i.v0} + {1'b0, res_i.v1}) : 2'd0;
  assign room_o  = (cnt_q <= RoomMax);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  // Pointer and fill bookkeeping
  always_comb begin
    rd_d  = do_pop ? ptr_inc(rd_q) : rd_q;
    wr_d  = wr_q;
    if (n_push == 2'd1)      wr_d = wr_nx;
    else if (n_push == 2'd2) wr_d = ptr_inc(wr_nx);
    cnt_d = cnt_q + CntW'(n_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (push_i && res_i.v0) mem_q[wr_q]  <= res_i.item0;
    if (push_i && res_i.v1) mem_q[wr_nx] <= res_i.item1;
  end

endmodule

// ----- sv/broadcast_packet_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_packet_parser: byte-stream parser for broadcast packets
// Decodes data, gossip, request and heartbeat packets into result beats.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                        tuser                tlast
//  s_axis    in   data_byte[7:0]               -                    last_byte
//  m_axis    out  origin..error_code (240 b)   item_kind,packet_type last_item
//
//  One input beat per cycle while there is room; each byte is parsed
//  combinationally from the held packet state. A byte may give two results
//  (an item and the end verdict); these leave the queue one per cycle while
//  m_axis_tready is high; input stalls only while fewer than two slots are free.
//  Reset empties the queue and puts the parser back to expecting a type byte.
// ----------------------------------------------------------------------------
module broadcast_packet_parser #(
  parameter int unsigned FIFO_DEPTH = bpp_pkg::FifoDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] origin, [127:64] sequence_res, [191:128] node_ident,
  // [223:192] payload_length, [231:224] payload_byte, [232] accepted,
  // [234:233] error_code, [239:235] zero
  output logic [239:0] m_axis_tdata,
  output logic [3:0]   m_axis_tuser,  // [1:0] item_kind, [3:2] packet_type
  output logic         m_axis_tlast   // last_item
);
  import bpp_pkg::*;

  logic       accept;
  logic       room;
  parse_out_t res;
  item_t      head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Packet parse
  bpp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .res_o   (res)
  );

  // Result queue
  bpp_out_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .res_i  (res),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .pop_i  (m_axis_tready),
    .item_o (head)
  );

  // Output beat packing
  assign m_axis_tdata = {5'd0, head.error_code, head.accepted, head.payload_byte,
                         head.payload_length, head.node_ident, head.sequence_res,
                         head.origin};
  assign m_axis_tuser = {head.ptype, head.kind};
  assign m_axis_tlast = head.last_item;

endmodule
